[rtl/kpe_pkg.sv]
package kpe_pkg;

    // Widths of the scan vector and of a key index.
    localparam int KEY_W  = 16;
    localparam int IDX_W  = 4;
    localparam int KIND_W = 2;

    // Number of keys that are really wired; scan bits above them are ignored.
    localparam int NUM_KEYS = 16;

    localparam logic [KEY_W-1:0] KEY_MASK =
        (NUM_KEYS >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((64'd1 << NUM_KEYS) - 64'd1);

    // Depth of the queue between the front and the back.
    localparam int FIFO_DEPTH = 2;

    // Event kinds: previous bit times two plus current bit.
    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PRESSED  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASED = 2'd2;

    // One classified scan, handed from the front to the back.
    typedef struct packed {
        logic [KEY_W-1:0]  prev;
        logic [KEY_W-1:0]  curr;
        logic              pressed_found;
        logic [IDX_W-1:0]  first_pressed_key;
        logic              released_found;
        logic [IDX_W-1:0]  first_released_key;
        logic [KIND_W-1:0] query_status;
    } job_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic {
        BK_IDLE,
        BK_BUSY
    } back_state_t;

    // Index of the lowest set bit; zero when no bit is set.
    function automatic logic [IDX_W-1:0] lowest_bit(input logic [KEY_W-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = KEY_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

[rtl/kpe_fifo.sv]
module kpe_fifo
    import kpe_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  job_t       push_job,
    input  logic       pop,
    output job_t       head_job,
    output fifo_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job   = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

[rtl/kpe_front.sv]
module kpe_front
    import kpe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [KEY_W-1:0]  scan_bits,
    input  logic [IDX_W-1:0]  query_key,
    input  fifo_stat_t        stat,
    output logic              push,
    output job_t              push_job
);

    logic [KEY_W-1:0] curr_scan_reg, curr_scan_next;
    logic [KEY_W-1:0] scan_masked;
    logic [KEY_W-1:0] pressed;
    logic [KEY_W-1:0] released;

    assign in_ready    = !stat.full;
    assign push        = in_valid && in_ready;
    assign scan_masked = scan_bits & KEY_MASK;
    assign pressed     = ~curr_scan_reg & scan_masked;
    assign released    = curr_scan_reg & ~scan_masked;

    always_comb
    begin
        curr_scan_next = push ? scan_masked : curr_scan_reg;

        push_job.prev               = curr_scan_reg;
        push_job.curr               = scan_masked;
        push_job.pressed_found      = (pressed != '0);
        push_job.first_pressed_key  = lowest_bit(pressed);
        push_job.released_found     = (released != '0);
        push_job.first_released_key = lowest_bit(released);
        if (32'(query_key) < NUM_KEYS)
        begin
            push_job.query_status = {curr_scan_reg[query_key], scan_masked[query_key]};
        end
        else
        begin
            push_job.query_status = KIND_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curr_scan_reg <= '0;
        end
        else
        begin
            curr_scan_reg <= curr_scan_next;
        end
    end

endmodule

[rtl/kpe_back.sv]
module kpe_back
    import kpe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  fifo_stat_t        stat,
    input  job_t              head_job,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              event_valid,
    output logic [IDX_W-1:0]  event_key,
    output logic [KIND_W-1:0] event_kind,
    output logic              last,
    output logic              pressed_found,
    output logic [IDX_W-1:0]  first_pressed_key,
    output logic              released_found,
    output logic [IDX_W-1:0]  first_released_key,
    output logic [KIND_W-1:0] query_status
);

    back_state_t state_reg, state_next;

    job_t             job_reg, job_next;
    logic [KEY_W-1:0] pend_reg, pend_next;

    logic              out_valid_reg, out_valid_next;
    logic              ev_valid_reg;
    logic [IDX_W-1:0]  ev_key_reg;
    logic [KIND_W-1:0] ev_kind_reg;
    logic              last_reg;
    job_t              res_job_reg;

    job_t              src_job;
    logic [KEY_W-1:0]  src_pend;
    logic [KEY_W-1:0]  rest;
    logic [IDX_W-1:0]  key;
    logic [KIND_W-1:0] kind;
    logic              has_change;
    logic              is_last;
    logic              slot_free;
    logic              emit;

    // Output decode: pick the job being worked on and form its next event.
    always_comb
    begin
        if (state_reg == BK_BUSY)
        begin
            src_job  = job_reg;
            src_pend = pend_reg;
        end
        else
        begin
            src_job  = head_job;
            src_pend = head_job.prev ^ head_job.curr;
        end
        has_change = (src_pend != '0);
        key        = lowest_bit(src_pend);
        rest       = src_pend & ~(KEY_W'(1) << key);
        is_last    = (rest == '0);
        kind       = has_change ? {src_job.prev[key], src_job.curr[key]} : KIND_NONE;
        slot_free  = !out_valid_reg || out_ready;
        emit       = slot_free && ((state_reg == BK_BUSY) || !stat.empty);
        pop        = emit && (state_reg == BK_IDLE);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (emit && !is_last)
                begin
                    state_next = BK_BUSY;
                end
            end
            BK_BUSY:
            begin
                if (emit && is_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        job_next       = emit ? src_job : job_reg;
        pend_next      = emit ? rest : pend_reg;
        out_valid_next = emit ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        pend_reg <= pend_next;
        if (emit)
        begin
            ev_valid_reg <= has_change;
            ev_key_reg   <= key;
            ev_kind_reg  <= kind;
            last_reg     <= is_last;
            res_job_reg  <= src_job;
        end
    end

    assign out_valid          = out_valid_reg;
    assign event_valid        = ev_valid_reg;
    assign event_key          = ev_key_reg;
    assign event_kind         = ev_kind_reg;
    assign last               = last_reg;
    assign pressed_found      = res_job_reg.pressed_found;
    assign first_pressed_key  = res_job_reg.first_pressed_key;
    assign released_found     = res_job_reg.released_found;
    assign first_released_key = res_job_reg.first_released_key;
    assign query_status       = res_job_reg.query_status;

endmodule

[rtl/keypad_edge_event_generator.sv]
// Channel  Handshake             Payload
// -------  --------------------  ------------------------------------------------
// input    in_valid / in_ready   scan_bits, query_key
// output   out_valid / out_ready event_valid, event_key, event_kind, last,
//                                pressed_found, first_pressed_key, released_found,
//                                first_released_key, query_status
//
// A scan with n changed keys yields max(n, 1) results, one per cycle while the output
// is not stalled; the serial walk over the changed-key vector produces them in turn.
// The front takes a new scan in any cycle in which the queue has room.
// Reset clears the stored scan to all keys released and empties the queue.
// A stalled output holds its result in the output register; the back stops and the
// queue fills, after which in_ready drops.
module keypad_edge_event_generator
    import kpe_pkg::*;
#(
    parameter int FIFO_DEPTH_P = FIFO_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [KEY_W-1:0]  scan_bits,
    input  logic [IDX_W-1:0]  query_key,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              event_valid,
    output logic [IDX_W-1:0]  event_key,
    output logic [KIND_W-1:0] event_kind,
    output logic              last,
    output logic              pressed_found,
    output logic [IDX_W-1:0]  first_pressed_key,
    output logic              released_found,
    output logic [IDX_W-1:0]  first_released_key,
    output logic [KIND_W-1:0] query_status
);

    // The front classifies each scan: it updates the stored scan and computes the
    // summary fields that every result of this scan repeats.
    fifo_stat_t stat;
    logic       push;
    logic       pop;
    job_t       push_job;
    job_t       head_job;

    kpe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .scan_bits (scan_bits),
        .query_key (query_key),
        .stat      (stat),
        .push      (push),
        .push_job  (push_job)
    );

    // The queue decouples the classification from the event serialization.
    kpe_fifo #(
        .DEPTH (FIFO_DEPTH_P)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .stat     (stat)
    );

    // The back walks the changed keys from the lowest index upward, one result
    // per cycle while the output is not stalled, into a registered output stage.
    kpe_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .stat               (stat),
        .head_job           (head_job),
        .pop                (pop),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .event_valid        (event_valid),
        .event_key          (event_key),
        .event_kind         (event_kind),
        .last               (last),
        .pressed_found      (pressed_found),
        .first_pressed_key  (first_pressed_key),
        .released_found     (released_found),
        .first_released_key (first_released_key),
        .query_status       (query_status)
    );

    // A real event is always a press or a release.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_valid |-> event_kind == KIND_PRESSED ||
                                     event_kind == KIND_RELEASED)
        else $error("event with kind other than press or release");

    // A result without an event is the sole result of its scan and carries zeros.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !event_valid |-> last && event_key == '0 && event_kind == KIND_NONE)
        else $error("empty result not flagged last or not zeroed");

    // A press event agrees with the summary: it exists and is not below the lowest.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_valid && event_kind == KIND_PRESSED |->
            pressed_found && event_key >= first_pressed_key)
        else $error("press event disagrees with pressed summary");

    // Likewise for release events.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_valid && event_kind == KIND_RELEASED |->
            released_found && event_key >= first_released_key)
        else $error("release event disagrees with released summary");

endmodule
